// ----- design/pdcm_pkg.sv -----
// Shared types, constants and the seven-segment decoder of the PWM duty-cycle meter.
// No dependencies; the controller, the datapath and the checker import it.
package pdcm_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int DVD_W       = COUNT_WIDTH + 7;
  localparam int REM_W       = COUNT_WIDTH + 1;
  localparam int STEP_W      = $clog2(DVD_W);

  localparam logic [6:0] DUTY_SCALE     = 7'd100;
  localparam logic [6:0] DUTY_MAX       = 7'd99;
  localparam logic [2:0] PRESCALE_RESET = 3'd5;

  localparam logic [6:0] SEG_0 = 7'b1111110;
  localparam logic [6:0] SEG_1 = 7'b0110000;
  localparam logic [6:0] SEG_2 = 7'b1101101;
  localparam logic [6:0] SEG_3 = 7'b1111001;
  localparam logic [6:0] SEG_4 = 7'b0110011;
  localparam logic [6:0] SEG_5 = 7'b1011011;
  localparam logic [6:0] SEG_6 = 7'b1011111;
  localparam logic [6:0] SEG_7 = 7'b1110000;
  localparam logic [6:0] SEG_8 = 7'b1111111;
  localparam logic [6:0] SEG_9 = 7'b1111011;

  typedef enum logic [1:0] {
    CTRL_IDLE,
    CTRL_DIVIDE,
    CTRL_WRITE
  } ctrl_state_e;

  typedef enum logic [1:0] {
    PH_WAIT_RISE,
    PH_WAIT_FALL,
    PH_WAIT_END
  } phase_e;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic write;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic need_div;
    logic div_last;
  } status_t;

  function automatic logic [6:0] seg7(input logic [3:0] digit);
    logic [6:0] pat;
    unique case (digit)
      4'd0:    pat = SEG_0;
      4'd1:    pat = SEG_1;
      4'd2:    pat = SEG_2;
      4'd3:    pat = SEG_3;
      4'd4:    pat = SEG_4;
      4'd5:    pat = SEG_5;
      4'd6:    pat = SEG_6;
      4'd7:    pat = SEG_7;
      4'd8:    pat = SEG_8;
      4'd9:    pat = SEG_9;
      default: pat = 7'b0000000;
    endcase
    return pat;
  endfunction

endpackage

// ----- design/pdcm_ctrl.sv -----
// Controller of the PWM duty-cycle meter: accepts items and sequences the divider.
// Depends on pdcm_pkg for the state, command and status types.
module pdcm_ctrl import pdcm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CTRL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    cmd_o      = '0;
    unique case (state_q)
      CTRL_IDLE: begin
        in_stall_o   = status_i.busy;
        cmd_o.accept = in_valid_i & ~status_i.busy;
        if (cmd_o.accept && status_i.need_div) begin
          state_d = CTRL_DIVIDE;
        end
      end
      CTRL_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = CTRL_WRITE;
        end
      end
      CTRL_WRITE: begin
        cmd_o.write = 1'b1;
        state_d     = CTRL_IDLE;
      end
      default: begin
        state_d = CTRL_IDLE;
      end
    endcase
  end

endmodule

// ----- design/pdcm_datapath.sv -----
// Datapath of the PWM duty-cycle meter: edge detection, prescaled period counter,
// restoring divider and the output register. Depends on pdcm_pkg.
module pdcm_datapath import pdcm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_data_i,
  input  logic       pwm_level_i,
  input  cmd_t       cmd_i,
  output status_t    status_o,
  input  logic       out_stall_i,
  output logic       out_valid_o,
  output logic [6:0] duty_percent_o,
  output logic [6:0] seg_tens_o,
  output logic [6:0] seg_ones_o,
  output logic       measure_done_o,
  output logic       over_range_o
);

  logic [2:0]             pl_q;
  phase_e                 phase_q, phase_d;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d, high_q, high_d, cnt_b;
  logic [6:0]             presc_q, presc_d, presc_b;
  logic                   sat_q, sat_d, sat_b;
  logic                   last_q;
  logic [6:0]             duty_q;
  logic                   rise, fall, restart;
  logic [7:0]             presc_nxt;

  logic [DVD_W-1:0]       dvd_q;
  logic [REM_W-1:0]       rem_q, rem_sh;
  logic [COUNT_WIDTH-1:0] dvsr_q;
  logic [STEP_W-1:0]      step_q;
  logic                   ge;
  logic [6:0]             duty_new;

  logic                   out_valid_q;
  logic [6:0]             out_duty_d;
  logic [14:0]            tens_prod;
  logic [3:0]             tens;
  logic [6:0]             ones_full;
  logic                   load_plain;

  assign rise = pwm_level_i & ~last_q;
  assign fall = ~pwm_level_i & last_q;

  always_comb begin
    phase_d = phase_q;
    high_d  = high_q;
    restart = 1'b0;
    unique case (phase_q)
      PH_WAIT_FALL: begin
        if (fall) begin
          high_d  = cnt_q;
          phase_d = PH_WAIT_END;
        end
      end
      PH_WAIT_END: begin
        if (rise) begin
          restart = 1'b1;
          phase_d = PH_WAIT_FALL;
        end
      end
      PH_WAIT_RISE: begin
        if (rise) begin
          restart = 1'b1;
          phase_d = PH_WAIT_FALL;
        end
      end
      default: begin
        phase_d = PH_WAIT_RISE;
      end
    endcase
  end

  // The counter counts on the same tick that restarts it; it is held before the first rise.
  always_comb begin
    cnt_b     = restart ? '0 : cnt_q;
    presc_b   = restart ? '0 : presc_q;
    sat_b     = restart ? 1'b0 : sat_q;
    cnt_d     = cnt_b;
    presc_d   = presc_b;
    sat_d     = sat_b;
    presc_nxt = {1'b0, presc_b} + 8'd1;
    if (phase_d != PH_WAIT_RISE) begin
      if (presc_nxt >= (8'd1 << pl_q)) begin
        presc_d = '0;
        if (cnt_b == '1) begin
          sat_d = 1'b1;
        end else begin
          cnt_d = cnt_b + 1'b1;
        end
      end else begin
        presc_d = presc_nxt[6:0];
      end
    end
  end

  assign status_o.need_div = (phase_q == PH_WAIT_END) & rise & ~sat_q & (cnt_q != '0);
  assign status_o.div_last = (step_q == STEP_W'(DVD_W - 1));
  assign status_o.busy     = out_valid_q & out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pl_q    <= PRESCALE_RESET;
      phase_q <= PH_WAIT_RISE;
      cnt_q   <= '0;
      presc_q <= '0;
      high_q  <= '0;
      sat_q   <= 1'b0;
      last_q  <= 1'b0;
      duty_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        pl_q <= cfg_data_i;
      end
      if (cmd_i.accept) begin
        phase_q <= phase_d;
        cnt_q   <= cnt_d;
        presc_q <= presc_d;
        high_q  <= high_d;
        sat_q   <= sat_d;
        last_q  <= pwm_level_i;
      end
      if (cmd_i.write) begin
        duty_q <= duty_new;
      end
    end
  end

  // Restoring division, one quotient bit per cycle; quotient bits shift into dvd_q.
  assign rem_sh = {rem_q[REM_W-2:0], dvd_q[DVD_W-1]};
  assign ge     = rem_sh >= {1'b0, dvsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (cmd_i.accept) begin
      step_q <= '0;
    end else if (cmd_i.div_step) begin
      step_q <= step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      dvd_q  <= DVD_W'(high_q) * DVD_W'(DUTY_SCALE);
      rem_q  <= '0;
      dvsr_q <= cnt_q;
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? rem_sh - REM_W'(dvsr_q) : rem_sh;
      dvd_q <= {dvd_q[DVD_W-2:0], ge};
    end
  end

  assign duty_new = (dvd_q > DVD_W'(DUTY_MAX)) ? DUTY_MAX : dvd_q[6:0];

  // Digit split: duty * 205 >> 11 equals duty / 10 over the whole duty range.
  assign load_plain = cmd_i.accept & ~status_o.need_div;
  assign out_duty_d = cmd_i.write ? duty_new : duty_q;
  assign tens_prod  = 15'(out_duty_d) * 15'(205);
  assign tens       = tens_prod[14:11];
  assign ones_full  = out_duty_d - 7'(tens) * 7'd10;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_plain || cmd_i.write) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_plain || cmd_i.write) begin
      duty_percent_o <= out_duty_d;
      seg_tens_o     <= seg7(tens);
      seg_ones_o     <= seg7(ones_full[3:0]);
      measure_done_o <= cmd_i.write;
      // A division only starts for a period that ended unsaturated.
      over_range_o   <= cmd_i.write ? 1'b0 : sat_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- design/pwm_duty_cycle_meter.sv -----
// A result is loaded into the output register at the edge that accepts its item; for an
// item that ends a valid period it is loaded after 23 divider steps and a write.
// Throughput: one item per cycle while results are taken; an item that ends a valid period
// holds the input through its divider steps and the write. Configuration writes are always
// taken (cfg_ready_o high).
// Reset clears the phase, counters, flags, duty and output valid; prescale_log2 goes to 5.
// Top level of the PWM duty-cycle meter; depends on pdcm_pkg, pdcm_ctrl, pdcm_datapath.
module pwm_duty_cycle_meter import pdcm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       pwm_level_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [6:0] duty_percent_o,
  output logic [6:0] seg_tens_o,
  output logic [6:0] seg_ones_o,
  output logic       measure_done_o,
  output logic       over_range_o
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  pdcm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pdcm_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i & cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .pwm_level_i    (pwm_level_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .duty_percent_o (duty_percent_o),
    .seg_tens_o     (seg_tens_o),
    .seg_ones_o     (seg_ones_o),
    .measure_done_o (measure_done_o),
    .over_range_o   (over_range_o)
  );

endmodule

// ----- design/pdcm_checker.sv -----
// Port-level checker of the PWM duty-cycle meter and its bind to the top level.
// Depends on pdcm_pkg for the digit patterns and duty limit.
module pdcm_checker import pdcm_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       cfg_valid_i,
  input logic       cfg_ready_o,
  input logic [2:0] cfg_data_i,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       pwm_level_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [6:0] duty_percent_o,
  input logic [6:0] seg_tens_o,
  input logic [6:0] seg_ones_o,
  input logic       measure_done_o,
  input logic       over_range_o
);

  logic [6:0] last_duty_q;
  logic       out_take;

  assign out_take = out_valid_o & ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_duty_q <= '0;
    end else if (out_take) begin
      last_duty_q <= duty_percent_o;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(duty_percent_o))
    else $error("stalled result item dropped or changed");

  a_duty_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> duty_percent_o <= DUTY_MAX)
    else $error("duty above cap");

  a_duty_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && !measure_done_o |-> duty_percent_o == last_duty_q)
    else $error("duty changed without a new measurement");

  a_done_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && measure_done_o |-> !over_range_o)
    else $error("measurement taken on a saturated period");

  a_tens_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && duty_percent_o < 7'd10 |-> seg_tens_o == SEG_0)
    else $error("tens digit wrong for a duty below ten");

endmodule

bind pwm_duty_cycle_meter pdcm_checker u_pdcm_checker (.*);
